[rtl/bit_field_message_buffer_defines.svh]
// Assertion macros for the bit field message buffer.
// Included by the module that carries concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef BIT_FIELD_MESSAGE_BUFFER_DEFINES_SVH
`define BIT_FIELD_MESSAGE_BUFFER_DEFINES_SVH

// check outside reset
`define BFMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define BFMB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/bfmb_pkg.sv]
// Shared constants for the bit field message buffer.
// No dependencies; used by bfmb_scan, bit_field_message_buffer and the testbench.
package bfmb_pkg;

    localparam int DEF_STORE_BYTES = 1024;
    localparam int FIELD_W         = 32;
    localparam int NB_W            = 7;
    localparam int POS_OUT_W       = 11;
    localparam int CFG_W           = 11;
    localparam int CNT_W           = 6;

    // request codes
    localparam logic [2:0] REQ_WRITE      = 3'd0;
    localparam logic [2:0] REQ_READ       = 3'd1;
    localparam logic [2:0] REQ_WRITE_DLT  = 3'd2;
    localparam logic [2:0] REQ_READ_DLT   = 3'd3;
    localparam logic [2:0] REQ_RESTART_WR = 3'd4;
    localparam logic [2:0] REQ_RESTART_RD = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd1;
    localparam logic [1:0] ST_OVF       = 2'd2;
    localparam logic [1:0] ST_SHORT     = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_SIZE = 1'b0;
    localparam logic CFG_ALLOW    = 1'b1;

endpackage

[rtl/bfmb_store.sv]
// Byte store of the message buffer: one port, registered read each cycle, plus a write when enabled.
// Depends on nothing but its parameter.
module bfmb_store #(
    parameter int STORE_BYTES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STORE_BYTES)-1:0] i_addr,
    input  logic [7:0]                     i_wdata,
    output logic [7:0]                     o_rdata
);
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfmb_scan.sv]
// Serial bit length unit: finds the significant bit count of a magnitude, 4 bits a cycle.
// Depends on bfmb_pkg.
module bfmb_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bfmb_pkg::FIELD_W-1:0] i_mag,
    output logic                         o_busy,
    output logic [bfmb_pkg::CNT_W-1:0]   o_bits
);
    import bfmb_pkg::*;

    logic [FIELD_W-1:0] r_sh;
    logic [2:0]         r_k;
    logic [CNT_W-1:0]   r_bits;
    logic               r_busy;

    // top set bit of a nibble, counted from 1
    function automatic logic [2:0] nib_len(input logic [3:0] x);
        logic [2:0] len;
        len = 3'd0;
        if (x[0]) len = 3'd1;
        if (x[1]) len = 3'd2;
        if (x[2]) len = 3'd3;
        if (x[3]) len = 3'd4;
        return len;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_k == 3'd7) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= i_mag;
            r_k    <= 3'd0;
            r_bits <= CNT_W'(1);
        end else if (r_busy) begin
            if (r_sh[3:0] != 4'd0) begin
                r_bits <= CNT_W'({r_k, 2'b00}) + CNT_W'(nib_len(r_sh[3:0]));
            end
            r_sh <= r_sh >> 4;
            r_k  <= r_k + 3'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_bits = r_bits;

endmodule

[rtl/bit_field_message_buffer.sv]
// Bit field message buffer: packs and unpacks LSB-first bit fields in a byte store.
// Depends on bfmb_pkg, bfmb_store, bfmb_scan and bit_field_message_buffer_defines.svh.
//
// One request word in, one result word out. Fields move one bit per cycle
// into or out of the byte store, a write through a shift register; a read
// also stops in an address state for each store byte touched (the store's
// registered read port). A request passes through check, then the bit states
// if the field is accepted, then next and done. A delta write first runs the
// bit length scan of the difference, then writes the prefix and the field; a
// delta read is two reads back to back. Restarts and unused codes go from
// idle straight to done. One request is in work at a time; the result sits in
// an output register, so the next request is taken while the previous result
// is still waiting. Configuration is written through the separate
// configuration port; the user must write it only while the block is idle,
// the block itself does not enforce it.
module bit_field_message_buffer #(
    parameter int STORE_BYTES = bfmb_pkg::DEF_STORE_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [bfmb_pkg::CFG_W-1:0]     i_cfg_data,
    // request word
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_req_type,
    input  logic signed [31:0]             i_value,
    input  logic signed [31:0]             i_old_value,
    input  logic signed [bfmb_pkg::NB_W-1:0] i_num_bits,
    input  logic                           i_long_prefix,
    // result word
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [31:0]             o_read_value,
    output logic [1:0]                     o_status,
    output logic                           o_overflowed,
    output logic [bfmb_pkg::POS_OUT_W-1:0] o_size_bytes,
    output logic [bfmb_pkg::POS_OUT_W-1:0] o_read_bytes
);
    import bfmb_pkg::*;

    `include "bit_field_message_buffer_defines.svh"

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    // bit positions: byte count times 8 plus a field width, with headroom
    localparam int CW = ((PW > CFG_W) ? PW : CFG_W) + 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN0 = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_WBIT  = 4'd4;
    localparam logic [3:0] S_RADDR = 4'd5;
    localparam logic [3:0] S_RBIT  = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // control state
    logic [3:0]       r_state;
    logic [CFG_W-1:0] r_max;
    logic             r_allow;
    logic [PW-1:0]    r_wbyte;
    logic [2:0]       r_wbit;
    logic [PW-1:0]    r_rbyte;
    logic [2:0]       r_rbit;
    logic             r_ovf;
    logic             r_phase;
    logic             r_out_valid;

    // request and field datapath
    logic [7:0]             r_wacc;
    logic [2:0]             r_req;
    logic                   r_long;
    logic [31:0]            r_old;
    logic [31:0]            r_d;
    logic signed [NB_W-1:0] r_snb;
    logic [31:0]            r_sdata;
    logic                   r_sgn;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_cnt;
    logic [4:0]             r_i;
    logic [31:0]            r_res;
    logic                   r_rfail;
    logic [1:0]             r_sst;
    logic [1:0]             r_st1;
    logic [31:0]            r_rv;
    logic [1:0]             r_stf;

    // result register
    logic [31:0]          r_o_rv;
    logic [1:0]           r_o_st;
    logic                 r_o_ovf;
    logic [POS_OUT_W-1:0] r_o_size;
    logic [POS_OUT_W-1:0] r_o_rdb;

    logic             in_acc;
    logic             is_read;
    logic             nb_bad;
    logic [NB_W-1:0]  nb_abs;
    logic [CNT_W-1:0] n6;
    logic [CW-1:0]    cap_bytes;
    logic [CW-1:0]    cap_bits;
    logic [CW-1:0]    wpos;
    logic             w_over;
    logic             w_refuse;
    logic [CW-1:0]    rd_need;
    logic [CW-1:0]    rd_have;
    logic             rd_short;
    logic [7:0]       w_newacc;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_rdata;
    logic             scan_start;
    logic [31:0]      scan_mag;
    logic             scan_busy;
    logic [CNT_W-1:0] scan_bits;
    logic             fill;
    logic [31:0]      rd_ext;
    logic [31:0]      rd_final;
    logic [CNT_W-1:0] dr_b;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // width check and field length of the current sub-request
    assign is_read = (r_req == REQ_READ) || (r_req == REQ_READ_DLT);
    assign nb_bad  = (r_snb == '0) || (r_snb < -NB_W'(31)) || (r_snb > NB_W'(32));
    assign nb_abs  = r_snb[NB_W-1] ? (-r_snb) : r_snb;
    assign n6      = nb_abs[CNT_W-1:0];

    // capacity clamps to the store; a write that passes it overflows
    assign cap_bytes = (CW'(r_max) > CW'(STORE_BYTES)) ? CW'(STORE_BYTES) : CW'(r_max);
    assign cap_bits  = cap_bytes << 3;
    assign wpos      = CW'({r_wbyte, r_wbit});
    assign w_over    = (wpos + CW'(n6)) > cap_bits;
    assign w_refuse  = w_over && (!r_allow || (CW'(n6) > cap_bits));

    // bits left to read: whole written bytes past the read byte, plus the
    // rest of the byte that reading has started
    assign rd_need  = CW'({r_rbyte, 3'b000}) + CW'(n6);
    assign rd_have  = CW'({r_wbyte, 3'b000})
                    + ((r_rbit != 3'd0) ? CW'(4'd8 - {1'b0, r_rbit}) : CW'(0));
    assign rd_short = rd_need > rd_have;

    // a new byte starts cleared
    assign w_newacc = ((r_wbit == 3'd0) ? 8'd0 : r_wacc) | (8'(r_sdata[0]) << r_wbit);

    assign mem_we   = (r_state == S_WBIT);
    always_comb begin
        if (r_state == S_WBIT) begin
            mem_addr = r_wbyte[AW-1:0];
        end else if (r_rbit == 3'd0) begin
            mem_addr = r_rbyte[AW-1:0];
        end else begin
            mem_addr = AW'(r_rbyte - PW'(1));
        end
    end

    bfmb_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (w_newacc),
        .o_rdata (mem_rdata)
    );

    assign scan_start = (r_state == S_SCAN0);
    assign scan_mag   = r_d[31] ? (32'd0 - r_d) : r_d;

    bfmb_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_mag   (scan_mag),
        .o_busy  (scan_busy),
        .o_bits  (scan_bits)
    );

    // sign extension of a finished read, -1 when it failed
    assign fill = r_sgn && r_res[5'(r_n - CNT_W'(1))];
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            rd_ext[j] = (CNT_W'(j) < r_n) ? r_res[j] : fill;
        end
    end
    assign rd_final = r_rfail ? 32'hFFFF_FFFF : rd_ext;
    // delta read: field width from the prefix, a failed prefix counts as -1
    assign dr_b     = r_rfail ? CNT_W'(0) : (rd_final[CNT_W-1:0] + CNT_W'(1));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= CFG_W'(1024);
            r_allow <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_SIZE: r_max   <= i_cfg_data;
                CFG_ALLOW:    r_allow <= i_cfg_data[0];
                default:      r_allow <= r_allow;
            endcase
        end
    end

    // result valid: set when a result is loaded, cleared when it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wbyte     <= '0;
            r_wbit      <= 3'd0;
            r_rbyte     <= '0;
            r_rbit      <= 3'd0;
            r_ovf       <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase <= 1'b0;
                        case (i_req_type)
                            REQ_WRITE, REQ_READ, REQ_READ_DLT: r_state <= S_CHECK;
                            REQ_WRITE_DLT: r_state <= S_SCAN0;
                            REQ_RESTART_WR: begin
                                r_wbyte <= '0;
                                r_wbit  <= 3'd0;
                                r_rbyte <= '0;
                                r_rbit  <= 3'd0;
                                r_ovf   <= 1'b0;
                                r_state <= S_DONE;
                            end
                            REQ_RESTART_RD: begin
                                r_rbyte <= '0;
                                r_rbit  <= 3'd0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN0: r_state <= S_SCAN;
                S_SCAN: begin
                    if (!scan_busy) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (nb_bad) begin
                        r_state <= S_NEXT;
                    end else if (is_read) begin
                        r_state <= rd_short ? S_NEXT : S_RADDR;
                    end else begin
                        if (w_over) begin
                            r_ovf <= 1'b1;
                        end
                        if (w_refuse) begin
                            r_state <= S_NEXT;
                        end else begin
                            if (w_over) begin
                                r_wbyte <= '0;
                                r_wbit  <= 3'd0;
                            end
                            r_state <= S_WBIT;
                        end
                    end
                end
                S_WBIT: begin
                    r_wbit <= r_wbit + 3'd1;
                    if (r_wbit == 3'd7) begin
                        r_wbyte <= r_wbyte + PW'(1);
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_NEXT;
                    end
                end
                S_RADDR: r_state <= S_RBIT;
                S_RBIT: begin
                    if (r_rbit == 3'd0) begin
                        r_rbyte <= r_rbyte + PW'(1);
                    end
                    r_rbit <= r_rbit + 3'd1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_NEXT;
                    end else if (r_rbit == 3'd7) begin
                        r_state <= S_RADDR;
                    end
                end
                S_NEXT: begin
                    if ((r_req == REQ_WRITE_DLT || r_req == REQ_READ_DLT) && !r_phase) begin
                        r_phase <= 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_req   <= i_req_type;
                    r_long  <= i_long_prefix;
                    r_old   <= i_old_value;
                    r_d     <= i_value - i_old_value;
                    r_sdata <= i_value;
                    r_rv    <= 32'd0;
                    r_stf   <= ST_OK;
                    if (i_req_type == REQ_READ_DLT) begin
                        r_snb <= i_long_prefix ? NB_W'(5) : NB_W'(4);
                    end else begin
                        r_snb <= i_num_bits;
                    end
                end
            end
            S_SCAN: begin
                // prefix holds the bit count minus one
                r_snb   <= r_long ? NB_W'(5) : NB_W'(4);
                r_sdata <= 32'(scan_bits - CNT_W'(1));
            end
            S_CHECK: begin
                r_n   <= n6;
                r_cnt <= n6;
                r_i   <= 5'd0;
                r_res <= 32'd0;
                r_sgn <= r_snb[NB_W-1];
                if (nb_bad) begin
                    r_sst   <= ST_BAD_WIDTH;
                    r_rfail <= 1'b1;
                end else if (is_read) begin
                    r_sst   <= rd_short ? ST_SHORT : ST_OK;
                    r_rfail <= rd_short;
                end else begin
                    r_sst   <= w_refuse ? ST_OVF : ST_OK;
                    r_rfail <= 1'b0;
                end
            end
            S_WBIT: begin
                r_wacc  <= w_newacc;
                r_sdata <= r_sdata >> 1;
                r_cnt   <= r_cnt - CNT_W'(1);
            end
            S_RBIT: begin
                r_res[r_i] <= mem_rdata[r_rbit];
                r_i        <= r_i + 5'd1;
                r_cnt      <= r_cnt - CNT_W'(1);
            end
            S_NEXT: begin
                case (r_req)
                    REQ_WRITE: begin
                        r_stf <= r_sst;
                    end
                    REQ_READ: begin
                        r_stf <= r_sst;
                        r_rv  <= rd_final;
                    end
                    REQ_WRITE_DLT: begin
                        if (!r_phase) begin
                            // field is the bit count plus one, signed
                            r_st1   <= r_sst;
                            r_snb   <= -(NB_W'(scan_bits) + NB_W'(1));
                            r_sdata <= r_d;
                        end else begin
                            r_stf <= (r_st1 != ST_OK) ? r_st1 : r_sst;
                        end
                    end
                    REQ_READ_DLT: begin
                        if (!r_phase) begin
                            r_st1 <= r_sst;
                            r_snb <= -(NB_W'(dr_b) + NB_W'(1));
                        end else begin
                            r_stf <= (r_st1 != ST_OK) ? r_st1 : r_sst;
                            r_rv  <= r_old + rd_final;
                        end
                    end
                    default: r_stf <= r_sst;
                endcase
            end
            default: r_i <= r_i;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_o_rv   <= r_rv;
            r_o_st   <= r_stf;
            r_o_ovf  <= r_ovf;
            r_o_size <= POS_OUT_W'(r_wbyte);
            r_o_rdb  <= POS_OUT_W'(r_rbyte);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_o_rv;
    assign o_status     = r_o_st;
    assign o_overflowed = r_o_ovf;
    assign o_size_bytes = r_o_size;
    assign o_read_bytes = r_o_rdb;

    `BFMB_ASSERT(a_wr_in_store, (r_state == S_WBIT) |-> (r_wbyte < PW'(STORE_BYTES)), "write past store")
    `BFMB_ASSERT(a_rd_count, (r_state == S_RBIT) |-> (r_cnt != '0), "read bit with no count left")
    `BFMB_ASSERT(a_accept_busy, (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE), "accept did not start work")
    `BFMB_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset left block busy")

endmodule

[sim/bit_field_message_buffer_tb.sv]
// Self-checking testbench for bit_field_message_buffer: packed writes, reads, deltas.
// Depends on bfmb_pkg and the RTL of bit_field_message_buffer; nothing else.
module bit_field_message_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfmb_pkg::*;

    // one request word and one result word
    typedef struct {
        logic [2:0]  req;
        logic [31:0] val;
        logic [31:0] oldv;
        logic [6:0]  nb;
        logic        lng;
    } req_word_t;

    typedef struct {
        logic [31:0] rv;
        logic [1:0]  st;
        logic        ovf;
        logic [10:0] wsz;
        logic [10:0] rsz;
    } res_word_t;

    localparam int STORE_N = DEF_STORE_BYTES;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_req_type = '0;
    logic signed [31:0] i_value = '0;
    logic signed [31:0] i_old_value = '0;
    logic signed [NB_W-1:0] i_num_bits = '0;
    logic        i_long_prefix = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [31:0] o_read_value;
    logic [1:0]  o_status;
    logic        o_overflowed;
    logic [POS_OUT_W-1:0] o_size_bytes;
    logic [POS_OUT_W-1:0] o_read_bytes;

    bit_field_message_buffer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_value(i_value), .i_old_value(i_old_value),
        .i_num_bits(i_num_bits), .i_long_prefix(i_long_prefix),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_read_value(o_read_value), .o_status(o_status), .o_overflowed(o_overflowed),
        .o_size_bytes(o_size_bytes), .o_read_bytes(o_read_bytes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Packer shadow: its own copy of the store, positions and registers.
    // ------------------------------------------------------------------
    logic [7:0] pk_bytes [STORE_N];
    int unsigned pk_wr_byte, pk_wr_bit, pk_rd_byte, pk_rd_bit;
    logic        pk_ovf;
    int unsigned pk_max_size;
    logic        pk_allow;

    req_word_t   pending_words[$];
    res_word_t   awaited_results[$];
    int          n_errors = 0;
    int          n_words = 0;
    int          n_results = 0;
    int          n_ops[8];
    bit          no_idle = 0;       // phase with back to back traffic

    function automatic logic [1:0] pack_field(logic [31:0] val, int nb);
        int n;
        longint cap;
        logic [31:0] bits;
        if (nb == 0 || nb < -31 || nb > 32) return ST_BAD_WIDTH;
        n = nb < 0 ? -nb : nb;
        cap = longint'(pk_max_size > STORE_N ? STORE_N : pk_max_size) * 8;
        if (longint'(pk_wr_byte) * 8 + pk_wr_bit + n > cap) begin
            // overflow: refused unless wrapping is allowed and the field fits at all
            pk_ovf = 1'b1;
            if (!pk_allow || longint'(n) > cap) return ST_OVF;
            pk_wr_byte = 0;
            pk_wr_bit = 0;
        end
        bits = (n < 32) ? (val & ((32'd1 << n) - 32'd1)) : val;
        for (int i = 0; i < n; i++) begin
            if (pk_wr_byte < STORE_N) begin
                if (pk_wr_bit == 0) pk_bytes[pk_wr_byte] = 8'd0;
                if (bits[i]) pk_bytes[pk_wr_byte][pk_wr_bit] = 1'b1;
            end
            pk_wr_bit++;
            if (pk_wr_bit == 8) begin
                pk_wr_bit = 0;
                pk_wr_byte++;
            end
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] unpack_field(int nb, output logic [31:0] res);
        int n;
        bit sgn;
        longint avail;
        logic [31:0] r;
        r = '0;
        res = 32'hFFFF_FFFF;
        if (nb == 0 || nb < -31 || nb > 32) return ST_BAD_WIDTH;
        sgn = nb < 0;
        n = sgn ? -nb : nb;
        // bits of a partly written byte are not available
        avail = (longint'(pk_wr_byte) - longint'(pk_rd_byte)) * 8
              + (pk_rd_bit != 0 ? 8 - longint'(pk_rd_bit) : 0);
        if (longint'(n) > avail) return ST_SHORT;
        for (int i = 0; i < n; i++) begin
            if (pk_rd_bit == 0) pk_rd_byte++;
            if (pk_rd_byte - 1 < STORE_N && pk_bytes[pk_rd_byte - 1][pk_rd_bit]) r[i] = 1'b1;
            pk_rd_bit = (pk_rd_bit + 1) & 7;
        end
        if (sgn && n < 32 && r[n-1]) r = r | ~((32'd1 << n) - 32'd1);
        res = r;
        return ST_OK;
    endfunction

    function automatic res_word_t predict_result(req_word_t w);
        res_word_t o;
        logic [31:0] d, mag, r;
        logic [1:0] s2;
        int nb, bl, b;
        o.rv = '0;
        o.st = ST_OK;
        nb = int'($signed(w.nb));
        case (w.req)
            REQ_WRITE: o.st = pack_field(w.val, nb);
            REQ_READ:  o.st = unpack_field(nb, o.rv);
            REQ_WRITE_DLT: begin
                d = w.val - w.oldv;
                mag = d[31] ? (32'd0 - d) : d;
                bl = 1;
                mag = mag >> 1;
                while (mag != 0) begin
                    bl++;
                    mag = mag >> 1;
                end
                o.st = pack_field(32'(bl - 1), w.lng ? 5 : 4);
                s2 = pack_field(d, -(bl + 1));
                if (o.st == ST_OK) o.st = s2;
            end
            REQ_READ_DLT: begin
                o.st = unpack_field(w.lng ? 5 : 4, r);
                b = int'(r & 32'h3F);
                if (r == 32'hFFFF_FFFF) b = -1;
                b += 1;
                s2 = unpack_field(-(b + 1), r);
                if (o.st == ST_OK) o.st = s2;
                o.rv = w.oldv + r;
            end
            REQ_RESTART_WR: begin
                pk_wr_byte = 0; pk_wr_bit = 0;
                pk_rd_byte = 0; pk_rd_bit = 0;
                pk_ovf = 1'b0;
            end
            REQ_RESTART_RD: begin
                pk_rd_byte = 0; pk_rd_bit = 0;
            end
            default: ;
        endcase
        o.ovf = pk_ovf;
        o.wsz = 11'(pk_wr_byte);
        o.rsz = 11'(pk_rd_byte);
        return o;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the head of pending_words, predicts on acceptance.
    // ------------------------------------------------------------------
    int drv_gap = 0;
    always @(posedge i_clk) begin
        bit taken;
        int gap;
        taken = 0;
        gap = drv_gap;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                awaited_results.push_back(predict_result(pending_words[0]));
                n_ops[pending_words[0].req]++;
                n_words++;
                void'(pending_words.pop_front());
                taken = 1;
                gap = pick_gap();
            end
            // a stalled word stays put; otherwise idle out the gap or load the next
            if (!i_in_valid || taken) begin
                if (gap > 0) begin
                    gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_valid    <= 1'b1;
                    i_req_type    <= pending_words[0].req;
                    i_value       <= pending_words[0].val;
                    i_old_value   <= pending_words[0].oldv;
                    i_num_bits    <= pending_words[0].nb;
                    i_long_prefix <= pending_words[0].lng;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            drv_gap <= gap;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    int mon_stall = 0;
    always @(posedge i_clk) begin
        res_word_t e;
        int s;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word rv=%h st=%0d", $realtime,
                             o_read_value, o_status);
                    n_errors++;
                end else begin
                    e = awaited_results.pop_front();
                    if (o_read_value !== e.rv) begin
                        $display("%0t: read_value exp %h got %h", $realtime, e.rv, o_read_value);
                        n_errors++;
                    end
                    if (o_status !== e.st) begin
                        $display("%0t: status exp %0d got %0d", $realtime, e.st, o_status);
                        n_errors++;
                    end
                    if (o_overflowed !== e.ovf) begin
                        $display("%0t: overflowed exp %0d got %0d", $realtime, e.ovf,
                                 o_overflowed);
                        n_errors++;
                    end
                    if (o_size_bytes !== e.wsz) begin
                        $display("%0t: size_bytes exp %0d got %0d", $realtime, e.wsz,
                                 o_size_bytes);
                        n_errors++;
                    end
                    if (o_read_bytes !== e.rsz) begin
                        $display("%0t: read_bytes exp %0d got %0d", $realtime, e.rsz,
                                 o_read_bytes);
                        n_errors++;
                    end
                end
            end
            s = mon_stall;
            if (s > 0) begin
                s--;
                i_out_stall <= 1'b1;
            end else begin
                s = pick_gap();
                i_out_stall <= (s > 0);
                if (s > 0) s--;
            end
            mon_stall <= s;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_word(logic [2:0] req, logic [31:0] val, logic [31:0] oldv,
                                     int nb, logic lng);
        req_word_t w;
        w.req = req; w.val = val; w.oldv = oldv; w.nb = 7'(nb); w.lng = lng;
        pending_words.push_back(w);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 15));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // config writes happen only with the block idle
    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_SIZE) pk_max_size = data;
        else pk_allow = data[0];
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && awaited_results.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    // A packing session: restart, a run of writes, then the matching reads.
    function automatic void add_session();
        int n, w;
        int kind[$];
        int wid[$];
        logic [31:0] olds[$];
        logic lngs[$];
        logic [31:0] o;
        n = $urandom_range(1, 12);
        add_word(REQ_RESTART_WR, $urandom, $urandom, $urandom, 1'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                o = pick_value();
                kind.push_back(1);
                olds.push_back(o);
                lngs.push_back(1'($urandom));
                wid.push_back(0);
                add_word(REQ_WRITE_DLT, $urandom_range(0, 1) ? o + 32'($urandom_range(0, 40))
                         - 32'd20 : pick_value(), o, $urandom, lngs[$]);
            end else begin
                // mostly small fields, sign on a write is ignored
                w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32) : $urandom_range(1, 9);
                if (w < 32 && $urandom_range(0, 1)) w = -w;
                kind.push_back(0);
                wid.push_back(w);
                olds.push_back(0);
                lngs.push_back(0);
                add_word(REQ_WRITE, pick_value(), $urandom, w, 1'($urandom));
            end
        end
        for (int pass = 0; pass < ($urandom_range(0, 3) == 0 ? 2 : 1); pass++) begin
            if (pass > 0) add_word(REQ_RESTART_RD, $urandom, $urandom, $urandom, 1'($urandom));
            for (int i = 0; i < n; i++) begin
                if (kind[i] == 1) add_word(REQ_READ_DLT, $urandom, olds[i], $urandom, lngs[i]);
                else add_word(REQ_READ, $urandom, $urandom, wid[i], 1'($urandom));
            end
        end
        // sometimes read beyond what was written
        if ($urandom_range(0, 4) == 0)
            add_word(REQ_READ, $urandom, $urandom, $urandom_range(1, 32), 1'($urandom));
    endfunction

    function automatic void add_noise();
        add_word(3'($urandom), $urandom, $urandom, int'($urandom & 32'h7F), 1'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int cfg_sizes[8];
        int cfg_allow[8];
        int ph;
        cfg_sizes = '{1024, 0, 2047, 5, 5, 1, 64, 1024};
        cfg_allow = '{0, 0, 1, 0, 1, 1, 1, 1};
        foreach (pk_bytes[i]) pk_bytes[i] = 8'd0;
        pk_wr_byte = 0; pk_wr_bit = 0; pk_rd_byte = 0; pk_rd_bit = 0;
        pk_ovf = 0; pk_max_size = 1024; pk_allow = 0;
        foreach (n_ops[i]) n_ops[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, each request but write restart, invalid widths,
        // short reads, the 33-bit delta case, unused codes, at reset configuration.
        add_word(REQ_READ, 0, 0, 1, 0);                      // nothing written: short
        add_word(REQ_WRITE, 32'h8000_0001, 0, 32, 0);
        add_word(REQ_WRITE, 32'hFFFF_FFFF, 0, 1, 0);
        add_word(REQ_WRITE, 32'h7FFF_FFFF, 0, -31, 1);
        add_word(REQ_WRITE, 0, 0, 0, 0);                     // invalid widths
        add_word(REQ_WRITE, 0, 0, 33, 0);
        add_word(REQ_WRITE, 0, 0, -32, 0);
        add_word(REQ_READ, 0, 0, -64, 0);
        add_word(REQ_READ, 0, 0, 63, 0);
        add_word(REQ_READ, 0, 0, 32, 0);
        add_word(REQ_READ, 0, 0, -1, 0);
        add_word(REQ_READ, 0, 0, -31, 0);
        add_word(REQ_READ, 0, 0, 8, 0);                      // nothing left: short
        add_word(REQ_WRITE_DLT, 32'h8000_0000, 32'h0, 0, 0); // 33-bit field: invalid
        add_word(REQ_WRITE_DLT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
        add_word(REQ_WRITE_DLT, 32'd5, 32'd5, 0, 0);
        add_word(REQ_RESTART_RD, 0, 0, 0, 0);
        add_word(REQ_READ, 0, 0, 32, 0);
        add_word(REQ_READ, 0, 0, -31, 1);
        add_word(REQ_READ, 0, 0, 5, 0);
        add_word(REQ_READ_DLT, 0, 32'h0, 0, 0);
        add_word(REQ_READ_DLT, 0, 32'h8000_0000, 0, 1);
        add_word(REQ_READ_DLT, 0, 32'd5, 0, 0);              // runs out: short
        add_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 1);
        add_word(3'd7, 0, 0, 0, 0);
        drain();

        // Random phases over a sweep of capacities, wrap on and off.
        ph = 0;
        while (n_words < 1800) begin
            write_reg(CFG_MAX_SIZE, CFG_W'(cfg_sizes[ph % 8]));
            write_reg(CFG_ALLOW, CFG_W'(cfg_allow[ph % 8]));
            no_idle = (ph % 5 == 4);
            for (int k = 0; k < 12; k++) begin
                if ($urandom_range(0, 5) == 0) add_noise();
                else add_session();
            end
            drain();
            ph++;
        end

        repeat (100) @(posedge i_clk);
        $display("Ran %0d request words over %0d configurations, %0d results checked.",
                 n_words, ph + 1, n_results);
        $display("Writes %0d, reads %0d, delta writes %0d, delta reads %0d, restarts %0d.",
                 n_ops[REQ_WRITE], n_ops[REQ_READ], n_ops[REQ_WRITE_DLT],
                 n_ops[REQ_READ_DLT], n_ops[REQ_RESTART_WR] + n_ops[REQ_RESTART_RD]);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #20ms;
        $display("Timeout waiting for traffic to finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bfmb_pkg.sv
rtl/bfmb_store.sv
rtl/bfmb_scan.sv
rtl/bit_field_message_buffer.sv
sim/bit_field_message_buffer_tb.sv
